[src/aled_pkg.sv]
// Shared types, constants and ROM lookup functions for the accented letter
// escape decoder. No dependencies.
package aled_pkg;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;
  localparam int CODE_W = 6;
  localparam int LEN_W  = 3;
  localparam int ERR_W  = 3;
  localparam int ST_W   = 3;
  localparam int REG_W  = 3;

  // register indexes (byte address = 4 * index)
  localparam logic [REG_W-1:0] REG_EMPTY    = 3'd0;
  localparam logic [REG_W-1:0] REG_QUESTION = 3'd1;
  localparam logic [REG_W-1:0] REG_CH       = 3'd2;
  localparam logic [REG_W-1:0] REG_DZ       = 3'd3;
  localparam logic [REG_W-1:0] REG_DZH      = 3'd4;

  // decoder states
  localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [ST_W-1:0] ST_COMMA = 3'd1;
  localparam logic [ST_W-1:0] ST_CARON = 3'd2;
  localparam logic [ST_W-1:0] ST_COLON = 3'd3;
  localparam logic [ST_W-1:0] ST_GRAVE = 3'd4;
  localparam logic [ST_W-1:0] ST_GR_C  = 3'd5;
  localparam logic [ST_W-1:0] ST_GR_D  = 3'd6;
  localparam logic [ST_W-1:0] ST_GR_DV = 3'd7;

  // error kinds
  localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
  localparam logic [ERR_W-1:0] ERR_UNKNOWN   = 3'd1;
  localparam logic [ERR_W-1:0] ERR_COMMA     = 3'd2;
  localparam logic [ERR_W-1:0] ERR_CARON     = 3'd3;
  localparam logic [ERR_W-1:0] ERR_DIGRAPH   = 3'd4;
  localparam logic [ERR_W-1:0] ERR_COLON     = 3'd5;

  // escape characters
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_LOWER_V  = 8'h76;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_GRAVE    = 8'h60;
  localparam logic [7:0] CH_C        = 8'h43;
  localparam logic [7:0] CH_D        = 8'h44;
  localparam logic [7:0] CH_H        = 8'h48;
  localparam logic [7:0] CH_Z        = 8'h5A;

  typedef struct packed {
    logic [CODE_W-1:0] empty_code;
    logic [CODE_W-1:0] question_code;
    logic [CODE_W-1:0] ch_code;
    logic [CODE_W-1:0] dz_code;
    logic [CODE_W-1:0] dzh_code;
  } cfg_t;

  typedef struct packed {
    logic              emit;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic [ERR_W-1:0]  err;
  } res_t;

  typedef struct packed {
    logic              hit;
    logic [CODE_W-1:0] code;
  } rom_hit_t;

  function automatic rom_hit_t plain_lookup(input logic [7:0] c);
    rom_hit_t r;
    r.hit = 1'b1;
    unique case (c)
      8'h41:   r.code = 6'd1;
      8'h42:   r.code = 6'd4;
      8'h43:   r.code = 6'd5;
      8'h44:   r.code = 6'd7;
      8'h45:   r.code = 6'd11;
      8'h46:   r.code = 6'd13;
      8'h47:   r.code = 6'd14;
      8'h48:   r.code = 6'd15;
      8'h49:   r.code = 6'd17;
      8'h4A:   r.code = 6'd19;
      8'h4B:   r.code = 6'd20;
      8'h4C:   r.code = 6'd21;
      8'h4D:   r.code = 6'd24;
      8'h4E:   r.code = 6'd25;
      8'h4F:   r.code = 6'd27;
      8'h50:   r.code = 6'd30;
      8'h51:   r.code = 6'd31;
      8'h52:   r.code = 6'd32;
      8'h53:   r.code = 6'd34;
      8'h54:   r.code = 6'd36;
      8'h55:   r.code = 6'd38;
      8'h56:   r.code = 6'd40;
      8'h57:   r.code = 6'd41;
      8'h58:   r.code = 6'd42;
      8'h59:   r.code = 6'd43;
      8'h5A:   r.code = 6'd45;
      default: begin
        r.hit  = 1'b0;
        r.code = '0;
      end
    endcase
    return r;
  endfunction

  function automatic rom_hit_t long_lookup(input logic [7:0] c);
    rom_hit_t r;
    r.hit = 1'b1;
    unique case (c)
      8'h41:   r.code = 6'd2;
      8'h45:   r.code = 6'd12;
      8'h49:   r.code = 6'd18;
      8'h4C:   r.code = 6'd22;
      8'h4F:   r.code = 6'd28;
      8'h52:   r.code = 6'd33;
      8'h55:   r.code = 6'd39;
      8'h59:   r.code = 6'd44;
      8'h3F:   r.code = 6'd50;
      default: begin
        r.hit  = 1'b0;
        r.code = '0;
      end
    endcase
    return r;
  endfunction

  function automatic rom_hit_t caron_lookup(input logic [7:0] c);
    rom_hit_t r;
    r.hit = 1'b1;
    unique case (c)
      8'h43:   r.code = 6'd6;
      8'h44:   r.code = 6'd8;
      8'h4C:   r.code = 6'd23;
      8'h4E:   r.code = 6'd26;
      8'h4F:   r.code = 6'd29;
      8'h53:   r.code = 6'd35;
      8'h54:   r.code = 6'd37;
      8'h5A:   r.code = 6'd46;
      default: begin
        r.hit  = 1'b0;
        r.code = '0;
      end
    endcase
    return r;
  endfunction

  function automatic rom_hit_t dots_lookup(input logic [7:0] c);
    rom_hit_t r;
    r.hit = 1'b1;
    unique case (c)
      8'h41:   r.code = 6'd3;
      8'h55:   r.code = 6'd49;
      default: begin
        r.hit  = 1'b0;
        r.code = '0;
      end
    endcase
    return r;
  endfunction

endpackage

[src/aled_regs.sv]
// APB-style configuration registers of the escape decoder.
// Depends on aled_pkg.
module aled_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [aled_pkg::APB_AW-1:0] paddr,
  input  logic [aled_pkg::APB_DW-1:0] pwdata,
  output logic [aled_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output aled_pkg::cfg_t              cfg
);
  import aled_pkg::*;

  logic [REG_W-1:0] idx;
  logic             wr;

  assign idx    = paddr[APB_AW-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.empty_code    <= 6'd0;
      cfg.question_code <= 6'd47;
      cfg.ch_code       <= 6'd16;
      cfg.dz_code       <= 6'd9;
      cfg.dzh_code      <= 6'd10;
    end else if (wr) begin
      unique case (idx)
        REG_EMPTY:    cfg.empty_code    <= pwdata[CODE_W-1:0];
        REG_QUESTION: cfg.question_code <= pwdata[CODE_W-1:0];
        REG_CH:       cfg.ch_code       <= pwdata[CODE_W-1:0];
        REG_DZ:       cfg.dz_code       <= pwdata[CODE_W-1:0];
        REG_DZH:      cfg.dzh_code      <= pwdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_EMPTY:    prdata[CODE_W-1:0] = cfg.empty_code;
      REG_QUESTION: prdata[CODE_W-1:0] = cfg.question_code;
      REG_CH:       prdata[CODE_W-1:0] = cfg.ch_code;
      REG_DZ:       prdata[CODE_W-1:0] = cfg.dz_code;
      REG_DZH:      prdata[CODE_W-1:0] = cfg.dzh_code;
      default:      prdata = '0;
    endcase
  end

endmodule

[src/aled_decode.sv]
// Prefix state register and one-byte decode step with ROM lookups.
// Depends on aled_pkg.
module aled_decode (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [7:0]     in_char,
  input  aled_pkg::cfg_t cfg,
  output aled_pkg::res_t res,
  output logic [aled_pkg::ST_W-1:0] state
);
  import aled_pkg::*;

  logic [ST_W-1:0] state_next;
  rom_hit_t        plain_hit;
  rom_hit_t        long_hit;
  rom_hit_t        caron_hit;
  rom_hit_t        dots_hit;

  assign plain_hit = plain_lookup(in_char);
  assign long_hit  = long_lookup(in_char);
  assign caron_hit = caron_lookup(in_char);
  assign dots_hit  = dots_lookup(in_char);

  always_comb begin
    res        = '0;
    state_next = ST_IDLE;
    unique case (state)
      ST_IDLE: begin
        res.len = 3'd1;
        priority if (in_char == CH_DOT) begin
          res.emit = 1'b1;
          res.code = cfg.empty_code;
        end else if (in_char == CH_QUESTION) begin
          res.emit = 1'b1;
          res.code = cfg.question_code;
        end else if (in_char == CH_COMMA) begin
          state_next = ST_COMMA;
        end else if (in_char == CH_LOWER_V) begin
          state_next = ST_CARON;
        end else if (in_char == CH_COLON) begin
          state_next = ST_COLON;
        end else if (in_char == CH_GRAVE) begin
          state_next = ST_GRAVE;
        end else if (plain_hit.hit) begin
          res.emit = 1'b1;
          res.code = plain_hit.code;
        end else begin
          res.emit = 1'b1;
          res.err  = ERR_UNKNOWN;
        end
      end
      ST_COMMA: begin
        res.emit = 1'b1;
        res.len  = 3'd2;
        res.code = long_hit.hit ? long_hit.code : '0;
        res.err  = long_hit.hit ? ERR_OK : ERR_COMMA;
      end
      ST_CARON: begin
        res.emit = 1'b1;
        res.len  = 3'd2;
        res.code = caron_hit.hit ? caron_hit.code : '0;
        res.err  = caron_hit.hit ? ERR_OK : ERR_CARON;
      end
      ST_COLON: begin
        res.emit = 1'b1;
        res.len  = 3'd2;
        res.code = dots_hit.hit ? dots_hit.code : '0;
        res.err  = dots_hit.hit ? ERR_OK : ERR_COLON;
      end
      ST_GRAVE: begin
        res.len = 3'd2;
        priority if (in_char == CH_C) begin
          state_next = ST_GR_C;
        end else if (in_char == CH_D) begin
          state_next = ST_GR_D;
        end else begin
          res.emit = 1'b1;
          res.err  = ERR_DIGRAPH;
        end
      end
      ST_GR_C: begin
        res.emit = 1'b1;
        res.len  = 3'd3;
        res.code = (in_char == CH_H) ? cfg.ch_code : '0;
        res.err  = (in_char == CH_H) ? ERR_OK : ERR_DIGRAPH;
      end
      ST_GR_D: begin
        res.len = 3'd3;
        priority if (in_char == CH_Z) begin
          res.emit = 1'b1;
          res.code = cfg.dz_code;
        end else if (in_char == CH_LOWER_V) begin
          state_next = ST_GR_DV;
        end else begin
          res.emit = 1'b1;
          res.err  = ERR_DIGRAPH;
        end
      end
      ST_GR_DV: begin
        res.emit = 1'b1;
        res.len  = 3'd4;
        res.code = (in_char == CH_Z) ? cfg.dzh_code : '0;
        res.err  = (in_char == CH_Z) ? ERR_OK : ERR_DIGRAPH;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (step) begin
      state <= state_next;
    end
  end

endmodule

[src/accented_letter_escape_decoder_unit.sv]
// Top level of the accented letter escape decoder: input register, decode
// step and result register. Depends on aled_pkg, aled_regs, aled_decode.
//
// Usage:
//   Input channel: in_valid / in_stall with one byte, in_char, per beat.
//   Output channel: out_valid / out_stall with letter_code, sequence_length
//   and error_kind. A beat is taken when valid is high and stall is low.
//   A byte that only advances a prefix (',' 'v' ':' '`' and digraph
//   middles) yields no output beat; every other byte yields exactly one.
//   Path: the final byte of a sequence is taken into the input register,
//   and its result is decoded out of it into the result register.
//   Throughput: one byte per cycle while out_stall is low; the decode step is
//   one state update plus fixed ROM compares between the two registers.
//   Stall: while a result waits under out_stall, one more byte is still
//   taken into the input register; in_stall rises only when both are full.
//   Reset (rst, synchronous): clears both registers' valid flags, returns
//   the decoder to idle and loads the register reset codes.
//   Configuration: APB-style, registers at byte addresses 0,4,8,12,16;
//   write only while the block is idle.
module accented_letter_escape_decoder_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_char,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [aled_pkg::CODE_W-1:0] letter_code,
  output logic [aled_pkg::LEN_W-1:0]  sequence_length,
  output logic [aled_pkg::ERR_W-1:0]  error_kind,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [aled_pkg::APB_AW-1:0] paddr,
  input  logic [aled_pkg::APB_DW-1:0] pwdata,
  output logic [aled_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import aled_pkg::*;

  cfg_t            cfg;
  res_t            res;
  logic [ST_W-1:0] state;
  logic            s1_valid;
  logic [7:0]      s1_char;
  logic            out_free;
  logic            step;

  assign out_free = !out_valid || !out_stall;
  assign step     = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  aled_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  aled_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_char (s1_char),
    .cfg     (cfg),
    .res     (res),
    .state   (state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_char <= in_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      letter_code     <= res.code;
      sequence_length <= res.len;
      error_kind      <= res.err;
    end
  end

  a_err_zero_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_kind != ERR_OK |-> letter_code == '0)
    else $error("error beat carries a nonzero letter code");

  a_unknown_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_kind == ERR_UNKNOWN |-> sequence_length == 3'd1)
    else $error("unknown byte error with length other than one");

  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    step && res.emit |=> state == ST_IDLE)
    else $error("decoder not idle after a result");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with a free stage");

endmodule
